@@ rtl/ktpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ktpc_pkg
// shared constants and types for the kendall tau pair count unit
// ----------------------------------------------------------------------------
package ktpc_pkg;

  // fixed field widths
  localparam int IN_W    = 32;
  localparam int TAU_W   = 16;
  localparam int COUNT_W = 19;

  // saturation limit of the pair count outputs
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // defaults for the top level parameters
  localparam int MAX_SAMPLES_DEF  = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // quotient bits of the tau divider, one bit per step
  localparam int QUO_W     = TAU_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  // largest positive tau in q1.15
  localparam logic [TAU_W-1:0] TAU_POS_MAX = {1'b0, {(TAU_W-1){1'b1}}};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

@@ rtl/kendall_tau_pair_count_unit.sv @@
// ----------------------------------------------------------------------------
// kendall_tau_pair_count_unit
// kendall tau-a over a stream of (x, y) samples, scanned against a sample ram
// ----------------------------------------------------------------------------
// flow: busy stays high while the word is compared with each stored sample (none
//   if the store is empty or the word is dropped); a marked word adds a multiply,
//   a divide (none under two samples) and an emit step, then done strobes the
//   result for one cycle; a new word is taken only once busy is low, and one
//   stored sample is read and compared per cycle through the single ram read port
// reset: clears control, count, totals and overflow flag; the ram is not cleared
module kendall_tau_pair_count_unit #(
  parameter int MAX_SAMPLES  = ktpc_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = ktpc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // command side
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ktpc_pkg::IN_W-1:0]   x_sample,
  input  logic signed [ktpc_pkg::IN_W-1:0]   y_sample,
  input  logic                               last_sample,
  // result side
  output logic                               done,
  output logic signed [ktpc_pkg::TAU_W-1:0]  tau_scaled,
  output logic [ktpc_pkg::COUNT_W-1:0]       concordant_pairs,
  output logic [ktpc_pkg::COUNT_W-1:0]       discordant_pairs,
  output logic                               result_valid,
  output logic                               samples_dropped
);
  import ktpc_pkg::*;

  // key width: only the low bits of each field take part
  localparam int KW      = (SAMPLE_WIDTH < IN_W) ? SAMPLE_WIDTH : IN_W;
  localparam int ADDR_W  = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam longint unsigned MAX_PAIRS =
    (longint'(MAX_SAMPLES) * longint'(MAX_SAMPLES - 1)) / 2;
  localparam int TOT_W   = $clog2(MAX_PAIRS + 1);
  localparam int RW      = TOT_W + 1;
  localparam int SAT_W   = TOT_W + COUNT_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SAMPLES);

  state_t state;

  // accumulated state of the open data set
  logic [CNT_W-1:0]  count;
  logic [TOT_W-1:0]  conc_tot;
  logic [TOT_W-1:0]  disc_tot;
  logic              ovf;

  // the word being worked on
  logic [KW-1:0]     x_in;
  logic [KW-1:0]     y_in;
  logic              last_in;

  // scan pipeline: issue -> ram read -> compare -> accumulate
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  scan_len;
  logic              v_rd;
  logic              v_cmp;
  logic              inc_c;
  logic              inc_d;

  // sample ram, x in the upper half
  logic [2*KW-1:0]   store [MAX_SAMPLES];
  logic [2*KW-1:0]   rd_data;
  logic              mem_we;

  // tau divider
  logic [TOT_W-1:0]     den;
  logic [RW-1:0]        rem;
  logic [QUO_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 neg;
  logic                 n_ok;

  logic                 accept;
  logic                 full;
  logic                 issue;
  logic                 scan_done;
  logic [KW-1:0]        rd_x;
  logic [KW-1:0]        rd_y;
  logic                 x_gt, x_lt, y_gt, y_lt;
  logic [2*CNT_W-1:0]   prod;
  logic [RW-1:0]        r_sh;
  logic                 r_ge;
  logic [TAU_W-1:0]     tau_mag;
  logic [SAT_W-1:0]     conc_ext;
  logic [SAT_W-1:0]     disc_ext;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CNT_FULL);
  // a new sample lands at the next free slot, never one being scanned
  assign mem_we    = accept && !full;
  assign issue     = (state == ST_SCAN) && (rd_idx != scan_len);
  assign scan_done = !issue && !v_rd && !v_cmp;

  // ---------------------------------------------------------------------------
  // sample ram, one write and one registered read per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[count[ADDR_W-1:0]] <= {x_sample[KW-1:0], y_sample[KW-1:0]};
    end
    rd_data <= store[rd_idx[ADDR_W-1:0]];
  end

  // order of the new sample against the stored one, as signed values
  assign rd_x = rd_data[2*KW-1:KW];
  assign rd_y = rd_data[KW-1:0];
  assign x_gt = $signed(x_in) > $signed(rd_x);
  assign x_lt = $signed(x_in) < $signed(rd_x);
  assign y_gt = $signed(y_in) > $signed(rd_y);
  assign y_lt = $signed(y_in) < $signed(rd_y);

  // n(n-1), halved when registered into den
  assign prod = {{CNT_W{1'b0}}, count} * {{CNT_W{1'b0}}, count - 1'b1};

  // restoring divide step: the first step takes the integer bit, no shift
  assign r_sh = (div_cnt == '0) ? rem : {rem[RW-2:0], 1'b0};
  assign r_ge = (r_sh >= {1'b0, den});

  // saturate the magnitude at +1 only on the positive side
  always_comb begin
    if (neg) begin
      tau_mag = TAU_W'(~quo + 1'b1);
    end else if (quo[QUO_W-1]) begin
      tau_mag = TAU_POS_MAX;
    end else begin
      tau_mag = quo;
    end
  end

  assign conc_ext = {{COUNT_W{1'b0}}, conc_tot};
  assign disc_ext = {{COUNT_W{1'b0}}, disc_tot};

  // ---------------------------------------------------------------------------
  // control, scan accumulation and divider
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      conc_tot <= '0;
      disc_tot <= '0;
      ovf      <= 1'b0;
      rd_idx   <= '0;
      scan_len <= '0;
      v_rd     <= 1'b0;
      v_cmp    <= 1'b0;
      inc_c    <= 1'b0;
      inc_d    <= 1'b0;
      div_cnt  <= '0;
      done     <= 1'b0;
    end else begin
      // one-cycle strobe following the emit step
      done  <= (state == ST_EMIT);
      v_rd  <= issue;
      v_cmp <= v_rd;
      inc_c <= v_rd && ((x_gt && y_gt) || (x_lt && y_lt));
      inc_d <= v_rd && ((x_gt && y_lt) || (x_lt && y_gt));
      if (v_cmp) begin
        conc_tot <= conc_tot + TOT_W'(inc_c);
        disc_tot <= disc_tot + TOT_W'(inc_d);
      end
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            x_in    <= x_sample[KW-1:0];
            y_in    <= y_sample[KW-1:0];
            last_in <= last_sample;
            rd_idx  <= '0;
            // a dropped sample is not compared at all
            if (full) begin
              scan_len <= '0;
              ovf      <= 1'b1;
            end else begin
              scan_len <= count;
              count    <= count + 1'b1;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= last_in ? ST_MUL : ST_IDLE;
          end
        end
        ST_MUL: begin
          den     <= TOT_W'(prod >> 1);
          neg     <= (disc_tot > conc_tot);
          rem     <= (disc_tot > conc_tot) ? RW'(disc_tot - conc_tot)
                                           : RW'(conc_tot - disc_tot);
          n_ok    <= (count >= CNT_W'(2));
          quo     <= '0;
          div_cnt <= '0;
          state   <= (count >= CNT_W'(2)) ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          rem     <= r_ge ? (r_sh - {1'b0, den}) : r_sh;
          quo     <= {quo[QUO_W-2:0], r_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          result_valid    <= n_ok;
          samples_dropped <= ovf;
          if (n_ok) begin
            tau_scaled       <= tau_mag;
            concordant_pairs <= (conc_ext > SAT_W'(COUNT_MAX)) ? COUNT_MAX
                                                               : COUNT_W'(conc_ext);
            discordant_pairs <= (disc_ext > SAT_W'(COUNT_MAX)) ? COUNT_MAX
                                                               : COUNT_W'(disc_ext);
          end else begin
            tau_scaled       <= '0;
            concordant_pairs <= '0;
            discordant_pairs <= '0;
          end
          // close the data set
          count    <= '0;
          conc_tot <= '0;
          disc_tot <= '0;
          ovf      <= 1'b0;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result strobe only ever follows the emit step
  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EMIT))
    else $error("done without emit");

  // a word accepted on a full store marks the set as overflowed
  a_full_sets_ovf: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |=> ovf)
    else $error("overflow not flagged");

  // an accepted word starts its scan from the first stored sample
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (rd_idx == '0))
    else $error("scan not started");

  // the divider hands over to emit after its last step
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == DIV_LAST) |=> (state == ST_EMIT))
    else $error("divider overrun");
`endif

endmodule

@@ dv/tb_kendall_tau_pair_count_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kendall_tau_pair_count_unit
// self-checking bench for the kendall tau-a pair count unit
// ----------------------------------------------------------------------------
// drives sample words through the start/busy command port in bursts with
// random gaps, keeps a behavioral copy of the sample store and pair totals,
// and checks every strobed result field by field against the oldest
// prediction; directed data sets cover the extremes, ties, truncation of tau,
// short sets and a completely filled store, then random sets follow
// ----------------------------------------------------------------------------
module tb_kendall_tau_pair_count_unit;
  import ktpc_pkg::*;

  localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
  localparam int RANDOM_WORDS = 400;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  // how a random sample value is drawn
  typedef enum int {
    VAL_WIDE,      // any 32 bit value
    VAL_NARROW,    // -3..3, so ties are frequent
    VAL_LOW_END,   // at or just above the most negative value
    VAL_HIGH_END   // at or just below the most positive value
  } value_mode_t;

  typedef struct {
    logic signed [TAU_W-1:0] tau;
    logic [COUNT_W-1:0]      conc;
    logic [COUNT_W-1:0]      disc;
    logic                    valid;
    logic                    dropped;
  } tau_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] x_sample = '0;
  logic signed [IN_W-1:0] y_sample = '0;
  logic last_sample = 1'b0;
  logic done;
  logic signed [TAU_W-1:0] tau_scaled;
  logic [COUNT_W-1:0] concordant_pairs;
  logic [COUNT_W-1:0] discordant_pairs;
  logic result_valid;
  logic samples_dropped;

  // behavioral copy of the block state
  logic signed [IN_W-1:0] held_x [STORE_DEPTH];
  logic signed [IN_W-1:0] held_y [STORE_DEPTH];
  int held_count = 0;
  longint unsigned conc_sum = 0;
  longint unsigned disc_sum = 0;
  logic drop_seen = 1'b0;

  // results still owed by the block, oldest first
  tau_result_t tau_results_due [$];

  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int sets_closed = 0;
  int sets_invalid = 0;
  int sets_with_drop = 0;
  int burst_left = 0;

  kendall_tau_pair_count_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .x_sample         (x_sample),
    .y_sample         (y_sample),
    .last_sample      (last_sample),
    .done             (done),
    .tau_scaled       (tau_scaled),
    .concordant_pairs (concordant_pairs),
    .discordant_pairs (discordant_pairs),
    .result_valid     (result_valid),
    .samples_dropped  (samples_dropped)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #30_000_000;
    $display("kendall_tau_pair_count_unit regression: fail");
    $finish;
  end

  // fold one accepted word into the pair totals; on a marked word, close the
  // set and queue the result the block owes
  task automatic fold_sample(input logic signed [IN_W-1:0] xs,
                             input logic signed [IN_W-1:0] ys, input logic mark);
    int sx;
    int sy;
    longint unsigned n;
    longint unsigned den;
    longint unsigned mag;
    logic neg;
    tau_result_t r;
    if (held_count < STORE_DEPTH) begin
      for (int i = 0; i < held_count; i++) begin
        sx = (xs > held_x[i]) ? 1 : ((xs < held_x[i]) ? -1 : 0);
        sy = (ys > held_y[i]) ? 1 : ((ys < held_y[i]) ? -1 : 0);
        // a tie in either coordinate counts as neither
        if (sx != 0 && sy != 0) begin
          if (sx == sy) conc_sum++;
          else disc_sum++;
        end
      end
      held_x[held_count] = xs;
      held_y[held_count] = ys;
      held_count++;
    end else begin
      // store full: word refused, only the flag remembers it
      drop_seen = 1'b1;
    end
    if (!mark) return;
    r = '{tau: '0, conc: '0, disc: '0, valid: 1'b0, dropped: drop_seen};
    n = held_count;
    if (n >= 2) begin
      den = n * (n - 1) / 2;
      neg = disc_sum > conc_sum;
      // q1.15, truncated toward zero, +1 clips to the largest positive code
      mag = (neg ? disc_sum - conc_sum : conc_sum - disc_sum) * 32768 / den;
      if (!neg && mag > 32767) mag = 32767;
      if (neg && mag > 32768) mag = 32768;
      r.tau = neg ? TAU_W'(0 - mag) : TAU_W'(mag);
      r.conc = (conc_sum > COUNT_MAX) ? COUNT_MAX : COUNT_W'(conc_sum);
      r.disc = (disc_sum > COUNT_MAX) ? COUNT_MAX : COUNT_W'(disc_sum);
      r.valid = 1'b1;
    end else begin
      sets_invalid++;
    end
    if (drop_seen) sets_with_drop++;
    sets_closed++;
    // append at the tail, the checker takes from the head
    tau_results_due = {tau_results_due, r};
    held_count = 0;
    conc_sum = 0;
    disc_sum = 0;
    drop_seen = 1'b0;
  endtask

  // send one word: idle between bursts, then hold start until busy is low
  task automatic issue_sample(input logic signed [IN_W-1:0] xs,
                              input logic signed [IN_W-1:0] ys, input logic mark);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    start <= 1'b1;
    x_sample <= xs;
    y_sample <= ys;
    last_sample <= mark;
    do @(posedge clk); while (busy);
    // word taken at this edge
    fold_sample(xs, ys, mark);
    burst_left--;
    words_sent++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // every strobed result is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    tau_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (tau_results_due.size() == 0) begin
        $error("result with no data set closed: tau_scaled 0x%0h", tau_scaled);
        mismatches++;
      end else begin
        want = tau_results_due.pop_front();
        compare_field("tau_scaled", 32'(want.tau), 32'(tau_scaled));
        compare_field("concordant_pairs", 32'(want.conc), 32'(concordant_pairs));
        compare_field("discordant_pairs", 32'(want.disc), 32'(discordant_pairs));
        compare_field("result_valid", 32'(want.valid), 32'(result_valid));
        compare_field("samples_dropped", 32'(want.dropped), 32'(samples_dropped));
      end
    end
  end

  // short sets at the value extremes, including a lone sample
  task automatic test_extremes;
    // lone marked sample gives an invalid result
    issue_sample(32'sh0000_0001, -32'sd1, 1'b1);
    // extremes move together: tau = +1, clipped
    issue_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    issue_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    // extremes move apart: tau = -1
    issue_sample(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    issue_sample(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    // alternating bit patterns, every bit of both fields toggles
    issue_sample(32'sh5555_5555, 32'shaaaa_aaaa, 1'b0);
    issue_sample(32'shaaaa_aaaa, 32'sh5555_5555, 1'b0);
    issue_sample(32'sh0000_0000, 32'shffff_ffff, 1'b1);
  endtask

  // ties in x, in y and in both count as neither
  task automatic test_ties;
    issue_sample(32'sd7, 32'sd7, 1'b0);
    issue_sample(32'sd7, -32'sd3, 1'b0);
    issue_sample(32'sd2, 32'sd7, 1'b0);
    issue_sample(32'sd2, 32'sd7, 1'b0);
    issue_sample(32'sd9, 32'sd1, 1'b1);
    // all tied: valid result with zero counts
    issue_sample(32'sd4, 32'sd4, 1'b0);
    issue_sample(32'sd4, 32'sd4, 1'b1);
  endtask

  // (c - d) / den not exact, so the quotient truncates toward zero
  task automatic test_truncation;
    // c = 2, d = 1
    issue_sample(32'sd0, 32'sd0, 1'b0);
    issue_sample(32'sd1, 32'sd2, 1'b0);
    issue_sample(32'sd2, 32'sd1, 1'b1);
    // c = 1, d = 2
    issue_sample(32'sd0, 32'sd2, 1'b0);
    issue_sample(32'sd1, 32'sd0, 1'b0);
    issue_sample(32'sd2, 32'sd1, 1'b1);
  endtask

  // fill the store, then offer words it has to refuse, marked one last
  task automatic test_full_store;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      issue_sample(32'(i) - 32'sd512, 32'(3 * i) + 32'sd100, 1'b0);
    end
    issue_sample(-32'sd5, 32'sd99, 1'b0);
    issue_sample(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    // the flag must be gone for the next set
    issue_sample(32'sd1, 32'sd1, 1'b0);
    issue_sample(32'sd2, 32'sd2, 1'b1);
  endtask

  function automatic logic signed [IN_W-1:0] pick_value(input value_mode_t mode);
    case (mode)
      VAL_WIDE:     return $urandom;
      VAL_NARROW:   return 32'($urandom_range(0, 6)) - 32'sd3;
      VAL_LOW_END:  return 32'sh8000_0000 + 32'($urandom_range(0, 3));
      default:      return 32'sh7fff_ffff - 32'($urandom_range(0, 3));
    endcase
  endfunction

  // random data sets, mostly short, a few longer
  task automatic test_random_sets;
    int sent;
    int set_len;
    value_mode_t x_mode;
    value_mode_t y_mode;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                            : $urandom_range(1, 16);
      x_mode = value_mode_t'($urandom_range(0, 3));
      y_mode = value_mode_t'($urandom_range(0, 3));
      for (int k = 0; k < set_len; k++) begin
        // occasionally switch the set's value mode from this word on
        if ($urandom_range(0, 3) == 0) x_mode = value_mode_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) y_mode = value_mode_t'($urandom_range(0, 3));
        issue_sample(pick_value(x_mode), pick_value(y_mode), k == set_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_ties();
    test_truncation();
    test_full_store();
    test_random_sets();
    start <= 1'b0;
    // let the last set finish, then settle to catch stray strobes
    waited = 0;
    while (tau_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tau_results_due.size() != 0) begin
      $error("%0d results never arrived", tau_results_due.size());
      mismatches++;
    end
    $display("sent %0d sample words in %0d data sets, %0d results checked",
             words_sent, sets_closed, results_seen);
    $display("%0d sets too short to be valid, %0d sets with refused samples",
             sets_invalid, sets_with_drop);
    if (mismatches == 0) begin
      $display("kendall_tau_pair_count_unit regression: pass");
    end else begin
      $display("kendall_tau_pair_count_unit regression: fail");
    end
    $finish;
  end

endmodule
